// ===== src/kdlp_pkg.sv =====
package kdlp_pkg;

    // register widths and reset values
    localparam int unsigned FILTER_W = 8;
    localparam int unsigned HOLD_W   = 16;
    localparam int unsigned CFG_W    = 16;

    localparam logic [FILTER_W-1:0] FILTER_RESET = 8'd100;
    localparam logic [HOLD_W-1:0]   LONG_RESET   = 16'd700;
    localparam logic [HOLD_W-1:0]   HOLD_MAX     = 16'hFFFF;

    // configuration register indexes
    localparam logic CFG_PRESS_FILTER = 1'b0;
    localparam logic CFG_LONG_LIMIT   = 1'b1;

    // input beat: raw active-low key levels
    typedef struct packed {
        logic key_a_level;
        logic key_b_level;
    } t_in;

    // output beat
    typedef struct packed {
        logic a_short_event;
        logic a_long_event;
        logic b_short_event;
        logic b_long_event;
        logic a_held;
        logic b_held;
    } t_out;

    // what one lane reports for one tick
    typedef struct packed {
        logic short_ev;
        logic long_ev;
        logic held;
    } t_lane_res;

endpackage

// ===== src/kdlp_lane.sv =====
module kdlp_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_level,
    input  logic [kdlp_pkg::FILTER_W-1:0]     i_filter,
    input  logic [kdlp_pkg::HOLD_W-1:0]       i_long_limit,
    output kdlp_pkg::t_lane_res               o_res
);

    logic [kdlp_pkg::FILTER_W-1:0] r_press_cnt, n_press_cnt;
    logic [kdlp_pkg::FILTER_W-1:0] r_rel_cnt,   n_rel_cnt;
    logic [kdlp_pkg::HOLD_W-1:0]   r_hold_cnt,  n_hold_cnt;
    logic [kdlp_pkg::HOLD_W-1:0]   hold_inc;
    logic r_held,    n_held;
    logic r_judging, n_judging;
    logic r_judged,  n_judged;
    logic r_long,    n_long;
    logic short_ev, long_ev;

    // saturating hold counter increment
    assign hold_inc = (r_hold_cnt == kdlp_pkg::HOLD_MAX) ? r_hold_cnt
                                                         : r_hold_cnt + 1'b1;

    // next state of the lane for one tick
    always_comb begin
        n_press_cnt = r_press_cnt;
        n_rel_cnt   = r_rel_cnt;
        n_hold_cnt  = r_hold_cnt;
        n_held      = r_held;
        n_judging   = r_judging;
        n_judged    = r_judged;
        n_long      = r_long;
        short_ev    = 1'b0;
        long_ev     = 1'b0;
        if (!r_judging && !r_judged) begin
            if (!r_held) begin
                // press filter
                n_rel_cnt = i_filter;
                if (!i_level) begin
                    n_press_cnt = r_press_cnt - 1'b1;
                    if (r_press_cnt == {{(kdlp_pkg::FILTER_W-1){1'b0}}, 1'b1}) begin
                        n_held     = 1'b1;
                        n_long     = 1'b0;
                        n_hold_cnt = '0;
                        n_judging  = 1'b1;
                    end
                end else begin
                    n_press_cnt = i_filter;
                end
            end else begin
                // release filter
                n_press_cnt = i_filter;
                if (i_level) begin
                    n_rel_cnt = r_rel_cnt - 1'b1;
                    if (r_rel_cnt == {{(kdlp_pkg::FILTER_W-1){1'b0}}, 1'b1}) begin
                        n_held = 1'b0;
                    end
                end else begin
                    n_rel_cnt = i_filter;
                end
            end
        end else if (r_judging) begin
            // judging: count hold time, release ends it short
            if (!i_level) begin
                n_hold_cnt = hold_inc;
                if (hold_inc >= i_long_limit) begin
                    n_long    = 1'b1;
                    n_judging = 1'b0;
                    n_judged  = 1'b1;
                end
            end else begin
                n_judging = 1'b0;
                n_judged  = 1'b1;
            end
        end else begin
            // verdict beat
            n_judged = 1'b0;
            long_ev  = r_long;
            short_ev = !r_long;
        end
    end

    // state registers, advanced once per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_cnt <= kdlp_pkg::FILTER_RESET;
            r_rel_cnt   <= kdlp_pkg::FILTER_RESET;
            r_hold_cnt  <= '0;
            r_held      <= 1'b0;
            r_judging   <= 1'b0;
            r_judged    <= 1'b0;
            r_long      <= 1'b0;
        end else if (i_adv) begin
            r_press_cnt <= n_press_cnt;
            r_rel_cnt   <= n_rel_cnt;
            r_hold_cnt  <= n_hold_cnt;
            r_held      <= n_held;
            r_judging   <= n_judging;
            r_judged    <= n_judged;
            r_long      <= n_long;
        end
    end

    assign o_res.short_ev = short_ev;
    assign o_res.long_ev  = long_ev;
    assign o_res.held     = n_held;

`ifndef SYNTH
    // judging and verdict phases are exclusive
    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_judging && r_judged))
        else $error("lane judging and judged both set");

    // a lane being judged is always held
    a_judge_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_judging || r_judged) |-> r_held)
        else $error("lane judging without held");

    // verdict lasts exactly one beat
    a_verdict_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_judged && i_adv) |=> !r_judged)
        else $error("verdict phase not left after one beat");

    // never both verdicts on one beat
    a_one_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(short_ev && long_ev))
        else $error("short and long verdict together");
`endif

endmodule

// ===== src/kdlp_merge.sv =====
module kdlp_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  kdlp_pkg::t_lane_res   i_res_a,
    input  kdlp_pkg::t_lane_res   i_res_b,
    input  logic                  i_stall,
    output logic                  o_valid,
    output kdlp_pkg::t_out        o_data,
    output logic                  o_busy
);

    logic           r_valid;
    kdlp_pkg::t_out r_data;
    kdlp_pkg::t_out n_data;

    // combine both lanes into one beat
    always_comb begin
        n_data.a_short_event = i_res_a.short_ev;
        n_data.a_long_event  = i_res_a.long_ev;
        n_data.b_short_event = i_res_b.short_ev;
        n_data.b_long_event  = i_res_b.long_ev;
        n_data.a_held        = i_res_a.held;
        n_data.b_held        = i_res_b.held;
    end

    // output register: refilled in the same cycle it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_busy  = r_valid && i_stall;

`ifndef SYNTH
    // a waiting beat is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |-> !i_adv)
        else $error("output beat overwritten while stalled");

    // a stalled beat stays put
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> (r_valid && $stable(r_data)))
        else $error("stalled output beat changed");

    // one verdict per key per beat
    a_merge_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(r_data.a_short_event && r_data.a_long_event)
                 && !(r_data.b_short_event && r_data.b_long_event))
        else $error("conflicting verdicts in output beat");
`endif

endmodule

// ===== src/key_debounce_long_short_press_core.sv =====
// Two-key debouncer with short/long press verdicts, one lane per key.
// An accepted input beat's output beat is registered in the merge output register.
// Throughput: 1 beat per cycle while the output is not stalled; each lane updates its counters once per accepted beat.
// Reset (synchronous, active low): filters reload to 100, long limit 700,
// lanes idle and released, output register empty.
module key_debounce_long_short_press_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  kdlp_pkg::t_in                      i_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output kdlp_pkg::t_out                     o_data,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [kdlp_pkg::CFG_W-1:0]         i_cfg_data
);

    logic [kdlp_pkg::FILTER_W-1:0] r_filter;
    logic [kdlp_pkg::HOLD_W-1:0]   r_long_limit;
    logic                          adv;
    logic                          busy;
    kdlp_pkg::t_lane_res           res_a;
    kdlp_pkg::t_lane_res           res_b;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter     <= kdlp_pkg::FILTER_RESET;
            r_long_limit <= kdlp_pkg::LONG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kdlp_pkg::CFG_PRESS_FILTER: r_filter     <= i_cfg_data[kdlp_pkg::FILTER_W-1:0];
                kdlp_pkg::CFG_LONG_LIMIT:   r_long_limit <= i_cfg_data[kdlp_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // input beat taken whenever the output register can accept
    assign o_stall = busy;
    assign adv     = i_valid && !busy;

    kdlp_lane u_lane_a (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_level      (i_data.key_a_level),
        .i_filter     (r_filter),
        .i_long_limit (r_long_limit),
        .o_res        (res_a)
    );

    kdlp_lane u_lane_b (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_level      (i_data.key_b_level),
        .i_filter     (r_filter),
        .i_long_limit (r_long_limit),
        .o_res        (res_b)
    );

    kdlp_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_res_a  (res_a),
        .i_res_b  (res_b),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_data   (o_data),
        .o_busy   (busy)
    );

endmodule
